/* src/mee_pkg.sv */
// Shared types and constants for the MessagePack element encoder.
package mee_pkg;

	localparam logic [2:0] REQ_UINT  = 3'd0;
	localparam logic [2:0] REQ_BOOL  = 3'd1;
	localparam logic [2:0] REQ_STR   = 3'd2;
	localparam logic [2:0] REQ_BIN   = 3'd3;
	localparam logic [2:0] REQ_RAW   = 3'd4;
	localparam logic [2:0] REQ_ARRAY = 3'd5;
	localparam logic [2:0] REQ_MAP   = 3'd6;
	localparam logic [2:0] REQ_NONE  = 3'd7;

	localparam logic [7:0] MP_UINT8  = 8'hcc;
	localparam logic [7:0] MP_UINT16 = 8'hcd;
	localparam logic [7:0] MP_UINT32 = 8'hce;
	localparam logic [7:0] MP_UINT64 = 8'hcf;
	localparam logic [7:0] MP_FALSE  = 8'hc2;
	localparam logic [7:0] MP_TRUE   = 8'hc3;
	localparam logic [7:0] MP_FIXSTR = 8'ha0;
	localparam logic [7:0] MP_STR8   = 8'hd9;
	localparam logic [7:0] MP_BIN8   = 8'hc4;
	localparam logic [7:0] MP_BIN16  = 8'hc5;
	localparam logic [7:0] MP_FIXARR = 8'h90;
	localparam logic [7:0] MP_FIXMAP = 8'h80;
	localparam logic [7:0] MP_MAP16  = 8'hde;

	localparam int SEQ_BYTES = 9;
	localparam int SEQ_W     = 8 * SEQ_BYTES;

	// APB register word index
	localparam logic REG_BUFFER_LIMIT = 1'b0;

	// one classified element: bytes left-aligned, first byte in the top lane
	typedef struct packed {
		logic             err;
		logic [3:0]       nbytes;
		logic [SEQ_W-1:0] seq;
	} cmd_t;

endpackage

/* src/mee_front.sv */
// Front end: accepts elements, picks the encoding and tracks the sticky error.
module mee_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              q_full,
	input  logic [2:0]        req_type,
	input  logic [63:0]       value,
	input  logic [15:0]       length,
	input  logic [7:0]        data_byte,
	output logic              in_ready,
	output logic              q_push,
	output mee_pkg::cmd_t     q_cmd
);

	logic halted_q;
	logic bad_len;
	logic take;

	assign in_ready = ~q_full;
	assign take     = in_valid & in_ready;
	assign q_push   = take & (req_type != mee_pkg::REQ_NONE);

	always_comb begin
		bad_len = 1'b0;
		if (req_type == mee_pkg::REQ_STR && length[15:8] != 8'd0)
			bad_len = 1'b1;
		if (req_type == mee_pkg::REQ_ARRAY && length[15:4] != 12'd0)
			bad_len = 1'b1;
	end

	always_comb begin
		q_cmd.err    = halted_q | bad_len;
		q_cmd.nbytes = 4'd1;
		q_cmd.seq    = '0;
		if (!q_cmd.err) begin
			case (req_type)
				mee_pkg::REQ_UINT: begin
					if (value[63:7] == 57'd0) begin
						q_cmd.seq = {value[7:0], 64'd0};
					end else if (value[63:8] == 56'd0) begin
						q_cmd.nbytes = 4'd2;
						q_cmd.seq    = {mee_pkg::MP_UINT8, value[7:0], 56'd0};
					end else if (value[63:16] == 48'd0) begin
						q_cmd.nbytes = 4'd3;
						q_cmd.seq    = {mee_pkg::MP_UINT16, value[15:0], 48'd0};
					end else if (value[63:32] == 32'd0) begin
						q_cmd.nbytes = 4'd5;
						q_cmd.seq    = {mee_pkg::MP_UINT32, value[31:0], 32'd0};
					end else begin
						q_cmd.nbytes = 4'd9;
						q_cmd.seq    = {mee_pkg::MP_UINT64, value};
					end
				end
				mee_pkg::REQ_BOOL: begin
					q_cmd.seq = {(value != 64'd0) ? mee_pkg::MP_TRUE : mee_pkg::MP_FALSE,
						64'd0};
				end
				mee_pkg::REQ_STR: begin
					if (length[7:5] == 3'd0) begin
						q_cmd.seq = {mee_pkg::MP_FIXSTR | {3'd0, length[4:0]}, 64'd0};
					end else begin
						q_cmd.nbytes = 4'd2;
						q_cmd.seq    = {mee_pkg::MP_STR8, length[7:0], 56'd0};
					end
				end
				mee_pkg::REQ_BIN: begin
					if (length[15:8] == 8'd0) begin
						q_cmd.nbytes = 4'd2;
						q_cmd.seq    = {mee_pkg::MP_BIN8, length[7:0], 56'd0};
					end else begin
						q_cmd.nbytes = 4'd3;
						q_cmd.seq    = {mee_pkg::MP_BIN16, length, 48'd0};
					end
				end
				mee_pkg::REQ_RAW: begin
					q_cmd.seq = {data_byte, 64'd0};
				end
				mee_pkg::REQ_ARRAY: begin
					q_cmd.seq = {mee_pkg::MP_FIXARR | {4'd0, length[3:0]}, 64'd0};
				end
				mee_pkg::REQ_MAP: begin
					if (length[15:4] == 12'd0) begin
						q_cmd.seq = {mee_pkg::MP_FIXMAP | {4'd0, length[3:0]}, 64'd0};
					end else begin
						q_cmd.nbytes = 4'd3;
						q_cmd.seq    = {mee_pkg::MP_MAP16, length, 48'd0};
					end
				end
				default: begin
					q_cmd.seq = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (q_push && bad_len) begin
			halted_q <= 1'b1;
		end
	end

endmodule

/* src/mee_fifo.sv */
// Small register queue of classified elements between front and back.
module mee_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mee_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          nonempty,
	output mee_pkg::cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mee_pkg::cmd_t    entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* src/mee_back.sv */
// Back end: shifts out one byte per cycle unless the receiver stalls, and keeps the buffer byte count.
module mee_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   buffer_limit,
	input  logic          q_nonempty,
	input  mee_pkg::cmd_t q_head,
	output logic          q_pop,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          stored,
	output logic          last,
	output logic          error
);

	logic [mee_pkg::SEQ_W-1:0] seq_q;
	logic [3:0]                rem_q;
	logic                      err_q;
	logic                      act_q;
	logic [15:0]               written_q;
	logic                      emit;
	logic                      final_byte;
	logic                      keep;

	assign emit       = act_q & (~out_valid | out_ready);
	assign final_byte = (rem_q == 4'd1);
	// next element loads as the previous one hands out its final byte
	assign q_pop      = q_nonempty & (~act_q | (emit & final_byte));
	assign keep       = ~err_q & (written_q < buffer_limit);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			seq_q <= q_head.seq;
			rem_q <= q_head.nbytes;
			err_q <= q_head.err;
		end else if (emit) begin
			seq_q <= {seq_q[mee_pkg::SEQ_W-9:0], 8'd0};
			rem_q <= rem_q - 4'd1;
		end
		if (emit) begin
			out_byte <= seq_q[mee_pkg::SEQ_W-1 -: 8];
			stored   <= keep;
			last     <= final_byte;
			error    <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			out_valid <= 1'b0;
			written_q <= '0;
		end else begin
			if (q_pop)
				act_q <= 1'b1;
			else if (emit && final_byte)
				act_q <= 1'b0;
			if (emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (emit && keep)
				written_q <= written_q + 16'd1;
		end
	end

endmodule

/* src/msgpack_element_encoder_top.sv */
// Top level of the MessagePack element encoder: APB register, front, queue, back.
//
// Input channel (in_valid/in_ready) takes one typed element per transaction;
// req_type 7 is accepted and dropped without output. Output channel
// (out_valid/out_ready) carries one encoded byte per transaction, most
// significant byte first, with last on the final byte of each element.
// An element yields 1 to 9 bytes (uint64 is nine); the output register emits
// one byte per cycle while out_ready is high. The first byte passes through
// the queue, the back-end shift register and the output register. The queue
// holds QUEUE_DEPTH classified elements, so the front keeps accepting while
// the back is busy.
// An unsupported length (string of 256 or more, array above 15) gives one
// error byte and halts: later elements each give one error byte until reset.
// When the receiver stalls, the output byte holds, the queue fills and then
// in_ready drops. Reset clears the byte count, the error flag and the queue,
// and sets buffer_limit to 65535. buffer_limit sits at APB address 0.
module msgpack_element_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [63:0] value,
	input  logic [15:0] length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        stored,
	output logic        last,
	output logic        error
);

	logic [15:0]   buffer_limit_q;
	logic          q_full;
	logic          q_nonempty;
	logic          q_push;
	logic          q_pop;
	mee_pkg::cmd_t q_cmd;
	mee_pkg::cmd_t q_head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mee_pkg::REG_BUFFER_LIMIT) ? {16'd0, buffer_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_limit_q <= 16'hffff;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == mee_pkg::REG_BUFFER_LIMIT) begin
			buffer_limit_q <= pwdata[15:0];
		end
	end

	mee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.q_full    (q_full),
		.req_type  (req_type),
		.value     (value),
		.length    (length),
		.data_byte (data_byte),
		.in_ready  (in_ready),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	mee_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	mee_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.buffer_limit (buffer_limit_q),
		.q_nonempty   (q_nonempty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.stored       (stored),
		.last         (last),
		.error        (error)
	);

endmodule
